### hdl/dmbc_pkg.sv
// Package for the direct-mapped byte cache: operation codes and geometry constants.
`default_nettype none

package dmbc_pkg;

  typedef enum logic [1:0] {
    FuncRead  = 2'd0,
    FuncWrite = 2'd1,
    FuncInval = 2'd2
  } func_e;

  localparam int unsigned AddrW         = 16;
  localparam int unsigned DataW         = 8;
  localparam int unsigned Lines         = 256;
  localparam int unsigned IndexW        = $clog2(Lines);
  localparam int unsigned TagW          = AddrW - IndexW;
  localparam int unsigned EntryW        = TagW + DataW;
  localparam int unsigned BankRows      = Lines / 2;
  localparam int unsigned RowW          = IndexW - 1;
  localparam int unsigned MaxWriteBytes = 2;
  localparam int unsigned CountW        = 32;

endpackage

`default_nettype wire

### hdl/direct_mapped_byte_cache.sv
// Top level of the direct-mapped byte cache: lookup, fill, invalidate and hit/miss totals.
// Each input transfer passes the lookup stage and then the output register to become a result.
// Throughput: one item per cycle when not stalled; the tag/data lines sit in an even and an
// odd RAM bank, so a two-byte fill writes both banks in the same cycle as the transfer.
// Back-pressure on the output stalls the input only once both stages are full.
// Reset clears the valid flops and both totals at once; no clearing pass is run.
// Age and use counters never reach an output and are not kept.
`default_nettype none

module direct_mapped_byte_cache (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic        skip_i,
  input  wire logic [15:0] addr_i,
  input  wire logic [7:0]  write_byte0_i,
  input  wire logic [7:0]  write_byte1_i,
  input  wire logic [1:0]  write_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             hit_o,
  output logic [7:0]       read_byte_o,
  output logic [31:0]      hit_total_o,
  output logic [31:0]      miss_total_o
);

  import dmbc_pkg::*;

  logic              accept;
  func_e             func;
  logic              is_read;
  logic              is_write;
  logic              is_inval;
  logic [IndexW-1:0] idx0;
  logic [IndexW-1:0] idx1;
  logic [AddrW-1:0]  addr1;
  logic              wr0_en;
  logic              wr1_en;

  assign accept   = in_valid_i & ~in_stall_o;
  assign func     = func_e'(func_i);
  assign is_read  = accept & (func == FuncRead) & ~skip_i;
  assign is_write = accept & (func == FuncWrite) & ~skip_i;
  assign is_inval = accept & (func == FuncInval);
  assign idx0     = addr_i[IndexW-1:0];
  assign addr1    = addr_i + AddrW'(1);
  assign idx1     = addr1[IndexW-1:0];
  assign wr0_en   = is_write & (write_count_i != 2'd0);
  assign wr1_en   = is_write & (write_count_i >= 2'd2) & (MaxWriteBytes >= 2);

  // Banks by index parity; consecutive lines always land in different banks.
  logic [EntryW-1:0] rdata [2];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic            sel_first;
    logic            we;
    logic [RowW-1:0] waddr;
    logic [EntryW-1:0] wdata;
    logic            re;

    assign sel_first = (b == 1) ? idx0[0] : ~idx0[0];
    assign we        = sel_first ? wr0_en : wr1_en;
    assign waddr     = sel_first ? idx0[IndexW-1:1] : idx1[IndexW-1:1];
    assign wdata     = sel_first ? {addr_i[AddrW-1:IndexW], write_byte0_i}
                                 : {addr1[AddrW-1:IndexW], write_byte1_i};
    assign re        = is_read & sel_first;

    dmbc_ram #(
      .Width (EntryW),
      .Depth (BankRows)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (re),
      .raddr_i (idx0[IndexW-1:1]),
      .rdata_o (rdata[b])
    );
  end

  // Valid bits
  logic [Lines-1:0] valid_q, valid_d;

  always_comb begin
    valid_d = valid_q;
    if (is_inval) begin
      valid_d = '0;
    end
    if (wr0_en) begin
      valid_d[idx0] = 1'b1;
    end
    if (wr1_en) begin
      valid_d[idx1] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Lookup stage
  logic            s1_valid_q;
  logic            s1_read_q;
  logic            s1_bank_q;
  logic [TagW-1:0] s1_tag_q;
  logic            s1_line_valid_q;
  logic            out_valid_q;
  logic            advance;
  logic            s1_take;

  assign advance    = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = s1_valid_q & ~advance;
  assign s1_take    = advance & s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_read_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept | (s1_valid_q & ~advance);
      if (accept) begin
        s1_read_q <= is_read;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bank_q       <= idx0[0];
      s1_tag_q        <= addr_i[AddrW-1:IndexW];
      s1_line_valid_q <= valid_q[idx0];
    end
  end

  logic [EntryW-1:0] rd_entry;
  logic              s1_hit;
  logic              s1_miss;
  logic [CountW-1:0] hits_q, hits_d;
  logic [CountW-1:0] misses_q, misses_d;

  assign rd_entry = s1_bank_q ? rdata[1] : rdata[0];
  assign s1_hit   = s1_read_q & s1_line_valid_q & (rd_entry[EntryW-1:DataW] == s1_tag_q);
  assign s1_miss  = s1_read_q & ~s1_hit;
  assign hits_d   = (s1_take & s1_hit) ? hits_q + CountW'(1) : hits_q;
  assign misses_d = (s1_take & s1_miss) ? misses_q + CountW'(1) : misses_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Result register
  logic              out_hit_q;
  logic [DataW-1:0]  out_byte_q;
  logic [CountW-1:0] out_hits_q;
  logic [CountW-1:0] out_misses_q;

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      out_hit_q    <= s1_hit;
      out_byte_q   <= s1_hit ? rd_entry[DataW-1:0] : '0;
      out_hits_q   <= hits_d;
      out_misses_q <= misses_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign read_byte_o  = out_byte_q;
  assign hit_total_o  = out_hits_q;
  assign miss_total_o = out_misses_q;

  // Assertions
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  a_inval_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func == FuncInval && !wr0_en && !wr1_en) |=> (valid_q == '0))
    else $error("valid bits not cleared by invalidate");

  a_read_counts_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_take && s1_read_q) |=>
      (CountW'(hits_q + misses_q) == CountW'($past(hits_q + misses_q) + CountW'(1))))
    else $error("read transfer not counted exactly once");

  a_nonread_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_take && s1_read_q) |=> ($stable(hits_q) && $stable(misses_q)))
    else $error("totals changed without a read");

  a_miss_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_hit_q) |-> (out_byte_q == '0))
    else $error("nonzero byte on a miss");

endmodule

`default_nettype wire

### hdl/dmbc_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none

module dmbc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### verif/direct_mapped_byte_cache_checker.sv
// Checker for the direct-mapped byte cache: mirrors the cache contents and scores every result.
module direct_mapped_byte_cache_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [1:0]  func_i,
  input  wire logic        skip_i,
  input  wire logic [15:0] addr_i,
  input  wire logic [7:0]  write_byte0_i,
  input  wire logic [7:0]  write_byte1_i,
  input  wire logic [1:0]  write_count_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic        hit_i,
  input  wire logic [7:0]  read_byte_i,
  input  wire logic [31:0] hit_total_i,
  input  wire logic [31:0] miss_total_i,
  output int unsigned      mismatches_o,
  output int unsigned      pending_o,
  output int unsigned      compared_o,
  output int unsigned      read_hits_o
);
  import dmbc_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [7:0]  read_byte;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } result_t;

  localparam int unsigned FillLimit = (MaxWriteBytes < 2) ? MaxWriteBytes : 2;

  logic [AddrW-1:0] line_addr [Lines];
  logic [DataW-1:0] line_data [Lines];
  logic [Lines-1:0] line_ok;
  logic [31:0]      hit_count;
  logic [31:0]      miss_count;
  result_t          expected_q [$];

  function automatic result_t cache_access(input logic [1:0] func, input logic skip,
                                           input logic [15:0] addr, input logic [7:0] b0,
                                           input logic [7:0] b1, input logic [1:0] cnt);
    logic [IndexW-1:0] idx;
    int unsigned       nbytes;
    result_t           res;
    res = '0;
    idx = IndexW'(32'(addr) % Lines);
    if (func == FuncRead && !skip) begin
      if (line_ok[idx] && line_addr[idx] == addr) begin
        res.hit       = 1'b1;
        res.read_byte = line_data[idx];
        hit_count++;
      end else begin
        miss_count++;
      end
    end else if (func == FuncWrite && !skip) begin
      nbytes = (32'(cnt) > FillLimit) ? FillLimit : 32'(cnt);
      for (int i = 0; i < nbytes; i++) begin
        idx            = IndexW'((32'(addr) % Lines + 32'(i)) % Lines);
        line_addr[idx] = AddrW'(32'(addr) + 32'(i));
        line_data[idx] = (i == 0) ? b0 : b1;
        line_ok[idx]   = 1'b1;
      end
    end else if (func == FuncInval) begin
      // skip does not gate an invalidate
      line_ok = '0;
    end
    res.hit_total  = hit_count;
    res.miss_total = miss_count;
    return res;
  endfunction

  task automatic flag_error(input string what, input result_t want, input result_t got);
    mismatches_o++;
    if (mismatches_o <= 10)
      $display("%s: expected hit=%0d byte=%02h hits=%0d misses=%0d", what, want.hit,
               want.read_byte, want.hit_total, want.miss_total);
    if (mismatches_o <= 10)
      $display("  actual hit=%0d byte=%02h hits=%0d misses=%0d", got.hit, got.read_byte,
               got.hit_total, got.miss_total);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < Lines; k++) begin
        line_addr[k] = '0;
        line_data[k] = '0;
      end
      line_ok    = '0;
      hit_count  = '0;
      miss_count = '0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      // score the output before queueing this edge's input transfer
      if (out_valid_i && !out_stall_i) begin
        got = {hit_i, read_byte_i, hit_total_i, miss_total_i};
        if (expected_q.size() == 0) begin
          flag_error("result with nothing expected", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) flag_error("result mismatch", want, got);
        end
        compared_o++;
        if (got.hit === 1'b1) read_hits_o++;
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(cache_access(func_i, skip_i, addr_i, write_byte0_i,
                                          write_byte1_i, write_count_i));
      pending_o <= expected_q.size();
    end
  end

endmodule

### verif/direct_mapped_byte_cache_tb.sv
// Testbench top for the direct-mapped byte cache: clock, reset, stimulus, flow control, verdict.
module direct_mapped_byte_cache_tb;
  import dmbc_pkg::*;

  localparam logic [1:0]  FuncUnused  = 2'd3;
  localparam int unsigned RandomItems = 370;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned CycleLimit  = 200000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [1:0]  func_i        = FuncRead;
  logic        skip_i        = 1'b0;
  logic [15:0] addr_i        = '0;
  logic [7:0]  write_byte0_i = '0;
  logic [7:0]  write_byte1_i = '0;
  logic [1:0]  write_count_i = '0;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        hit_o;
  logic [7:0]  read_byte_o;
  logic [31:0] hit_total_o;
  logic [31:0] miss_total_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned compared;
  int unsigned read_hits;

  int unsigned tx_idle_pct = 12;
  int unsigned rx_idle_pct = 65;
  logic        hold_req    = 1'b0;
  logic        rx_hold     = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned n_read, n_write, n_inval, n_unused, n_skip;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  direct_mapped_byte_cache i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .skip_i        (skip_i),
    .addr_i        (addr_i),
    .write_byte0_i (write_byte0_i),
    .write_byte1_i (write_byte1_i),
    .write_count_i (write_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .read_byte_o   (read_byte_o),
    .hit_total_o   (hit_total_o),
    .miss_total_o  (miss_total_o)
  );

  direct_mapped_byte_cache_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .func_i        (func_i),
    .skip_i        (skip_i),
    .addr_i        (addr_i),
    .write_byte0_i (write_byte0_i),
    .write_byte1_i (write_byte1_i),
    .write_count_i (write_count_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_i         (hit_o),
    .read_byte_i   (read_byte_o),
    .hit_total_i   (hit_total_o),
    .miss_total_i  (miss_total_o),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .compared_o    (compared),
    .read_hits_o   (read_hits)
  );

  always @(posedge clk_i) begin
    out_stall_i <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  // long output hold-off, timed in its own process
  initial begin
    @(posedge hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("direct_mapped_byte_cache verification failed");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] func, input logic skip, input logic [15:0] addr,
                           input logic [7:0] b0, input logic [7:0] b1, input logic [1:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= func;
    skip_i        <= skip;
    addr_i        <= addr;
    write_byte0_i <= b0;
    write_byte1_i <= b1;
    write_count_i <= cnt;
    do @(posedge clk_i); while (in_stall_o);
    case (func)
      FuncRead:  n_read++;
      FuncWrite: n_write++;
      FuncInval: n_inval++;
      default:   n_unused++;
    endcase
    if (skip) n_skip++;
  endtask

  task automatic send_random();
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  hi;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55)      func = FuncRead;
    else if (pick < 94) func = FuncWrite;
    else if (pick < 97) func = FuncInval;
    else                func = FuncUnused;
    // mostly a small hot set with colliding tags and the index wrap near 0xff
    if ($urandom_range(9) < 8) begin
      case ($urandom_range(3))
        0:       hi = 8'h00;
        1:       hi = 8'h01;
        2:       hi = 8'hff;
        default: hi = 8'h80;
      endcase
      addr = {hi, 8'(8'($urandom_range(15)) - 8'd4)};
    end else begin
      addr = 16'($urandom);
    end
    send_item(func, $urandom_range(9) == 0, addr, 8'($urandom), 8'($urandom),
              2'($urandom_range(3)));
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    rx_idle_pct <= 65;

    send_item(FuncRead,   1'b0, 16'h0000, 8'h00, 8'h00, 2'd0);
    send_item(FuncWrite,  1'b0, 16'h0000, 8'hff, 8'h00, 2'd2);
    send_item(FuncRead,   1'b0, 16'h0000, 8'h00, 8'h00, 2'd0);
    send_item(FuncRead,   1'b0, 16'h0001, 8'h00, 8'h00, 2'd0);
    send_item(FuncWrite,  1'b0, 16'hffff, 8'ha5, 8'h5a, 2'd2);
    send_item(FuncRead,   1'b0, 16'hffff, 8'h00, 8'h00, 2'd0);
    send_item(FuncRead,   1'b0, 16'h0000, 8'h00, 8'h00, 2'd0);
    send_item(FuncRead,   1'b0, 16'h0100, 8'h00, 8'h00, 2'd0);
    send_item(FuncWrite,  1'b0, 16'h1234, 8'h77, 8'h88, 2'd0);
    send_item(FuncRead,   1'b0, 16'h1234, 8'h00, 8'h00, 2'd0);
    send_item(FuncWrite,  1'b0, 16'h2000, 8'h11, 8'h22, 2'd3);
    send_item(FuncRead,   1'b0, 16'h2001, 8'h00, 8'h00, 2'd0);
    send_item(FuncRead,   1'b0, 16'h2002, 8'h00, 8'h00, 2'd0);
    send_item(FuncWrite,  1'b1, 16'h3000, 8'h33, 8'h44, 2'd2);
    send_item(FuncRead,   1'b0, 16'h3000, 8'h00, 8'h00, 2'd0);
    send_item(FuncRead,   1'b1, 16'hffff, 8'hff, 8'hff, 2'd3);
    send_item(FuncUnused, 1'b0, 16'hffff, 8'hff, 8'hff, 2'd3);
    send_item(FuncInval,  1'b1, 16'h0000, 8'h00, 8'h00, 2'd0);
    send_item(FuncRead,   1'b0, 16'hffff, 8'h00, 8'h00, 2'd0);
    send_item(FuncWrite,  1'b0, 16'h4000, 8'h5c, 8'hc5, 2'd1);
    send_item(FuncRead,   1'b0, 16'h4000, 8'h00, 8'h00, 2'd0);
    send_item(FuncRead,   1'b0, 16'h4001, 8'h00, 8'h00, 2'd0);
    send_item(FuncInval,  1'b0, 16'hffff, 8'hff, 8'hff, 2'd3);
    send_item(FuncRead,   1'b0, 16'h4000, 8'h00, 8'h00, 2'd0);

    repeat (RandomItems) send_random();
    wait_all_results();

    tx_idle_pct = 65;
    rx_idle_pct <= 12;
    repeat (RandomItems) send_random();
    wait_all_results();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req    <= 1'b1;
    repeat (RandomItems) send_random();
    wait_all_results();
    repeat (10) @(posedge clk_i);

    $display("%0d items: %0d reads, %0d writes, %0d invalidates, %0d unused code, %0d skipped",
             n_read + n_write + n_inval + n_unused, n_read, n_write, n_inval, n_unused, n_skip);
    $display("%0d results compared, %0d read hits, %0d mismatches; %0d-cycle output hold",
             compared, read_hits, mismatches, HoldCycles);
    if (mismatches == 0) begin
      $display("direct_mapped_byte_cache verification clean");
    end else begin
      $display("direct_mapped_byte_cache verification failed");
    end
    $finish;
  end

endmodule
